/* src/sjet_pkg.sv */
`timescale 1ns / 1ps
package sjet_pkg;

    // up to three data bytes of two output bytes each per source byte
    localparam int RUN_MAX   = 6;
    localparam int RUN_CNT_W = 3;

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]    count;
    } t_run;

    // charset modes
    localparam logic [1:0] MODE_ASCII = 2'd0;
    localparam logic [1:0] MODE_KANJI = 2'd1;
    localparam logic [1:0] MODE_KANA  = 2'd2;

    // escape parse stage
    localparam logic [1:0] ESC_IDLE  = 2'd0;
    localparam logic [1:0] ESC_START = 2'd1;
    localparam logic [1:0] ESC_MID   = 2'd2;

    // control and escape characters
    localparam logic [7:0] CH_ESC  = 8'h1b;
    localparam logic [7:0] CH_SI   = 8'h0f;
    localparam logic [7:0] CH_SO   = 8'h0e;
    localparam logic [7:0] CH_K    = 8'h4b;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_DOL  = 8'h24;
    localparam logic [7:0] CH_PAR  = 8'h28;
    localparam logic [7:0] CH_AT   = 8'h40;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_J    = 8'h4a;
    localparam logic [7:0] CH_I    = 8'h49;

    localparam logic [7:0] KANA_PREFIX = 8'h8e;
    localparam logic [7:0] HIGH_BIT    = 8'h80;
    localparam logic [7:0] TRAIL_BASE  = 8'h40;
    localparam logic [7:0] TRAIL_BUMP  = 8'h9f;
    localparam logic [7:0] DEL_CODE    = 8'h7f;

    localparam logic [7:0] LEAD_MAP [128] = '{
        8'h80,8'ha1,8'ha3,8'ha5,8'ha7,8'ha9,8'hab,8'had,
        8'haf,8'hb1,8'hb3,8'hb5,8'hb7,8'hb9,8'hbb,8'hbd,
        8'hbf,8'hc1,8'hc3,8'hc5,8'hc7,8'hc9,8'hcb,8'hcd,
        8'hcf,8'hd1,8'hd3,8'hd5,8'hd7,8'hd9,8'hdb,8'hdd,
        8'ha0,8'ha1,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
        8'ha8,8'ha9,8'haa,8'hab,8'hac,8'had,8'hae,8'haf,
        8'hb0,8'hb1,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,
        8'hb8,8'hb9,8'hba,8'hbb,8'hbc,8'hbd,8'hbe,8'hbf,
        8'hc0,8'hc1,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,
        8'hc8,8'hc9,8'hca,8'hcb,8'hcc,8'hcd,8'hce,8'hcf,
        8'hd0,8'hd1,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,
        8'hd8,8'hd9,8'hda,8'hdb,8'hdc,8'hdd,8'hde,8'hdf,
        8'hdf,8'he1,8'he3,8'he5,8'he7,8'he9,8'heb,8'hed,
        8'hef,8'hf1,8'hf3,8'hf5,8'hf7,8'hf9,8'hfb,8'hfd,
        8'hf0,8'hf1,8'hf2,8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,
        8'hf8,8'hf9,8'hfa,8'hfb,8'hfc,8'hfd,8'hfe,8'hff
    };

    localparam logic [7:0] TRAIL_MAP [192] = '{
        8'ha1,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,
        8'ha9,8'haa,8'hab,8'hac,8'had,8'hae,8'haf,8'hb0,
        8'hb1,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,
        8'hb9,8'hba,8'hbb,8'hbc,8'hbd,8'hbe,8'hbf,8'hc0,
        8'hc1,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,
        8'hc9,8'hca,8'hcb,8'hcc,8'hcd,8'hce,8'hcf,8'hd0,
        8'hd1,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,
        8'hd9,8'hda,8'hdb,8'hdc,8'hdd,8'hde,8'hdf,8'h7f,
        8'he0,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,
        8'he8,8'he9,8'hea,8'heb,8'hec,8'hed,8'hee,8'hef,
        8'hf0,8'hf1,8'hf2,8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,
        8'hf8,8'hf9,8'hfa,8'hfb,8'hfc,8'hfd,8'hfe,8'ha1,
        8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,
        8'haa,8'hab,8'hac,8'had,8'hae,8'haf,8'hb0,8'hb1,
        8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,
        8'hba,8'hbb,8'hbc,8'hbd,8'hbe,8'hbf,8'hc0,8'hc1,
        8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,
        8'hca,8'hcb,8'hcc,8'hcd,8'hce,8'hcf,8'hd0,8'hd1,
        8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,
        8'hda,8'hdb,8'hdc,8'hdd,8'hde,8'hdf,8'he0,8'he1,
        8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,
        8'hea,8'heb,8'hec,8'hed,8'hee,8'hef,8'hf0,8'hf1,
        8'hf2,8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,
        8'hfa,8'hfb,8'hfc,8'hfd,8'hfe,8'hfd,8'hfe,8'hff
    };

endpackage

/* src/sjet_front.sv */
`timescale 1ns / 1ps
module sjet_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic            i_sjis_input,
    input  logic            i_in_valid,
    input  logic [7:0]      i_in_byte,
    input  logic            i_end_of_text,
    input  logic            i_q_full,
    output logic            o_in_ready,
    output logic            o_push,
    output sjet_pkg::t_run  o_run
);

    // result of one data byte: new held lead and 0..2 output bytes
    typedef struct packed {
        logic [7:0] held;
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_db;

    logic       r_sjis;
    logic [1:0] r_mode;
    logic       r_so;
    logic [7:0] r_held;
    logic [1:0] r_stage;
    logic [7:0] r_mid;

    logic [1:0] n_mode;
    logic       n_so;
    logic [7:0] n_held;
    logic [1:0] n_stage;
    logic [7:0] n_mid;
    sjet_pkg::t_run n_run;
    logic       in_acc;

    function automatic logic is_lead(input logic [7:0] c);
        return (c >= 8'h81 && c <= 8'h9f) || (c >= 8'he0 && c <= 8'hfc);
    endfunction

    function automatic logic is_trail(input logic [7:0] c);
        return c >= sjet_pkg::TRAIL_BASE && c <= 8'hfc && c != sjet_pkg::DEL_CODE;
    endfunction

    function automatic logic is_kana(input logic [7:0] c);
        return c >= 8'ha0 && c <= 8'hdf;
    endfunction

    function automatic t_db data_byte(input logic [7:0] c, input logic sjis,
                                      input logic [1:0] mode, input logic so,
                                      input logic [7:0] held);
        t_db        r;
        logic       done;
        logic [7:0] cv;
        r.held = held;
        r.cnt  = 2'd0;
        r.b0   = 8'h00;
        r.b1   = 8'h00;
        done   = 1'b0;
        if (sjis) begin
            if (held != 8'h00) begin
                r.held = 8'h00;
                if (is_trail(c)) begin
                    r.b0 = held + {7'd0, c >= sjet_pkg::TRAIL_BUMP};
                    r.b1 = sjet_pkg::TRAIL_MAP[c - sjet_pkg::TRAIL_BASE];
                    r.cnt = 2'd2;
                    done = 1'b1;
                end
            end
            if (!done && is_lead(c)) begin
                r.held = sjet_pkg::LEAD_MAP[c[6:0]];
                done = 1'b1;
            end else if (!done && is_kana(c)) begin
                r.b0 = sjet_pkg::KANA_PREFIX;
                r.b1 = c;
                r.cnt = 2'd2;
                done = 1'b1;
            end
        end
        if (!done) begin
            cv = (mode != sjet_pkg::MODE_ASCII || so) ? (c | sjet_pkg::HIGH_BIT) : c;
            if (mode == sjet_pkg::MODE_KANA || so) begin
                r.b0 = sjet_pkg::KANA_PREFIX;
                r.b1 = cv;
                r.cnt = 2'd2;
            end else begin
                r.b0 = cv;
                r.cnt = 2'd1;
            end
        end
        return r;
    endfunction

    function automatic sjet_pkg::t_run push(input sjet_pkg::t_run x, input t_db d);
        sjet_pkg::t_run y;
        y = x;
        if (d.cnt != 2'd0) begin
            y.bytes[x.count] = d.b0;
        end
        if (d.cnt == 2'd2) begin
            y.bytes[x.count + 3'd1] = d.b1;
        end
        y.count = x.count + {1'b0, d.cnt};
        return y;
    endfunction

    assign o_in_ready = !i_q_full;
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_push     = in_acc && (n_run.count != '0);
    assign o_run      = n_run;

    always_comb begin
        logic [7:0] c;
        logic       pre_esc;
        logic       pre_mid;
        logic       do_fresh;
        t_db        d;
        c        = i_in_byte;
        n_mode   = r_mode;
        n_so     = r_so;
        n_held   = r_held;
        n_stage  = r_stage;
        n_mid    = r_mid;
        n_run    = '0;
        pre_esc  = 1'b0;
        pre_mid  = 1'b0;
        do_fresh = 1'b0;
        d        = '0;

        case (r_stage)
            sjet_pkg::ESC_IDLE: begin
                do_fresh = 1'b1;
            end
            sjet_pkg::ESC_START: begin
                n_stage = sjet_pkg::ESC_IDLE;
                if (c == sjet_pkg::CH_K) begin
                    n_mode = sjet_pkg::MODE_KANJI;
                    n_so   = 1'b0;
                end else if (c == sjet_pkg::CH_H) begin
                    n_mode = sjet_pkg::MODE_ASCII;
                    n_so   = 1'b0;
                end else if (c == sjet_pkg::CH_AMP || c == sjet_pkg::CH_DOL ||
                             c == sjet_pkg::CH_PAR) begin
                    n_stage = sjet_pkg::ESC_MID;
                    n_mid   = c;
                end else begin
                    pre_esc  = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            default: begin
                n_stage = sjet_pkg::ESC_IDLE;
                if (r_mid == sjet_pkg::CH_AMP && c == sjet_pkg::CH_AT) begin
                    n_stage = sjet_pkg::ESC_IDLE;
                end else if (r_mid == sjet_pkg::CH_DOL &&
                             (c == sjet_pkg::CH_B || c == sjet_pkg::CH_AT)) begin
                    n_mode = sjet_pkg::MODE_KANJI;
                    n_so   = 1'b0;
                end else if (r_mid == sjet_pkg::CH_PAR &&
                             (c == sjet_pkg::CH_J || c == sjet_pkg::CH_B ||
                              c == sjet_pkg::CH_H)) begin
                    n_mode = sjet_pkg::MODE_ASCII;
                    n_so   = 1'b0;
                end else if (r_mid == sjet_pkg::CH_PAR && c == sjet_pkg::CH_I) begin
                    n_mode = sjet_pkg::MODE_KANA;
                end else begin
                    pre_esc  = 1'b1;
                    pre_mid  = 1'b1;
                    do_fresh = 1'b1;
                end
            end
        endcase

        // unmatched escape bytes go out as data, then the byte itself
        if (pre_esc) begin
            d      = data_byte(sjet_pkg::CH_ESC, r_sjis, n_mode, n_so, n_held);
            n_held = d.held;
            n_run  = push(n_run, d);
        end
        if (pre_mid) begin
            d      = data_byte(r_mid, r_sjis, n_mode, n_so, n_held);
            n_held = d.held;
            n_run  = push(n_run, d);
        end
        if (do_fresh) begin
            if (c == sjet_pkg::CH_SI) begin
                n_so = 1'b0;
            end else if (c == sjet_pkg::CH_SO) begin
                n_so = 1'b1;
            end else if (c == sjet_pkg::CH_ESC) begin
                n_stage = sjet_pkg::ESC_START;
            end else begin
                d      = data_byte(c, r_sjis, n_mode, n_so, n_held);
                n_held = d.held;
                n_run  = push(n_run, d);
            end
        end

        // end of text: flush a pending escape, drop lead, clear shift
        if (i_end_of_text) begin
            if (n_stage != sjet_pkg::ESC_IDLE) begin
                d      = data_byte(sjet_pkg::CH_ESC, r_sjis, n_mode, n_so, n_held);
                n_held = d.held;
                n_run  = push(n_run, d);
            end
            if (n_stage == sjet_pkg::ESC_MID) begin
                d      = data_byte(n_mid, r_sjis, n_mode, n_so, n_held);
                n_held = d.held;
                n_run  = push(n_run, d);
            end
            n_stage = sjet_pkg::ESC_IDLE;
            n_held  = 8'h00;
            n_so    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sjis  <= 1'b0;
            r_mode  <= sjet_pkg::MODE_ASCII;
            r_so    <= 1'b0;
            r_held  <= 8'h00;
            r_stage <= sjet_pkg::ESC_IDLE;
            r_mid   <= 8'h00;
        end else begin
            if (i_cfg_valid) begin
                r_sjis <= i_sjis_input;
            end
            if (in_acc) begin
                r_mode  <= n_mode;
                r_so    <= n_so;
                r_held  <= n_held;
                r_stage <= n_stage;
                r_mid   <= n_mid;
            end
        end
    end

endmodule

/* src/sjet_queue.sv */
`timescale 1ns / 1ps
module sjet_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sjet_pkg::t_run  i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output sjet_pkg::t_run  o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sjet_pkg::t_run r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= wrap_inc(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= wrap_inc(r_rptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

/* src/sjet_back.sv */
`timescale 1ns / 1ps
module sjet_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  sjet_pkg::t_run  i_q_data,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run
);

    sjet_pkg::t_run                 r_cur;
    logic [sjet_pkg::RUN_CNT_W-1:0] r_idx;
    logic                           r_busy;

    logic last;
    logic fin;

    assign last          = (r_idx == r_cur.count - sjet_pkg::RUN_CNT_W'(1));
    assign fin           = r_busy && i_out_ready && last;
    assign o_pop         = (!r_busy || fin) && i_q_valid;
    assign o_out_valid   = r_busy;
    assign o_out_byte    = r_cur.bytes[r_idx];
    assign o_last_of_run = last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (fin) begin
            r_busy <= 1'b0;
        end else if (r_busy && i_out_ready) begin
            r_idx <= r_idx + sjet_pkg::RUN_CNT_W'(1);
        end
    end

endmodule

/* src/sjis_or_jis_to_euc_transcoder.sv */
`timescale 1ns / 1ps
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------
// cfg      | i_cfg_valid / o_cfg_ready | i_sjis_input
// in       | i_in_valid  / o_in_ready  | i_in_byte, i_end_of_text
// out      | o_out_valid / i_out_ready | o_out_byte, o_last_of_run
//
// The front decodes one source byte per cycle while the queue is not full,
// turning it into a run of 0..6 EUC-JP bytes in that same cycle; runs wait
// in a QUEUE_DEPTH deep queue. The back sends one byte per cycle while
// i_out_ready is high, finishing a run before the next; items producing no
// bytes are not queued. o_in_ready drops only while the queue is full.
// Reset is synchronous, active low; it clears decode state and the queue.
module sjis_or_jis_to_euc_transcoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_sjis_input,
    // source bytes
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    // EUC-JP bytes
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    logic           q_full;
    logic           q_valid;
    logic           q_push;
    logic           q_pop;
    sjet_pkg::t_run front_run;
    sjet_pkg::t_run q_data;

    // config register is always writable (write it only while the block is idle; the block does not enforce this)
    assign o_cfg_ready = 1'b1;

    // front: escape parsing, Shift_JIS lead/trail mapping, mode handling
    sjet_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_sjis_input (i_sjis_input),
        .i_in_valid   (i_in_valid),
        .i_in_byte    (i_in_byte),
        .i_end_of_text(i_end_of_text),
        .i_q_full     (q_full),
        .o_in_ready   (o_in_ready),
        .o_push       (q_push),
        .o_run        (front_run)
    );

    // decouples decode from output back-pressure
    sjet_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (front_run),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_data (q_data)
    );

    // back: serializes each run, flags its final byte
    sjet_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_data),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run)
    );

endmodule

/* src/sjet_checker.sv */
`timescale 1ns / 1ps
module sjet_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_last_of_run
);

    // stalled output transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_last_of_run))
        else $error("output changed while stalled");

    // a run that is not finished keeps going
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_of_run |=> i_out_valid)
        else $error("run ended without last byte");

    // input back-pressure only when output side is holding work
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with idle output");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind sjis_or_jis_to_euc_transcoder sjet_checker u_sjet_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (o_in_ready),
    .i_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .i_out_byte   (o_out_byte),
    .i_last_of_run(o_last_of_run)
);
